// ===== rtl/owt_pkg.sv =====
// ----------------------------------------------------------------------------
// owt_pkg
// Types, codes and command plans shared by the one-wire temperature master.
// ----------------------------------------------------------------------------
package owt_pkg;

	localparam int REG_WIDTH = 16;
	localparam int NUM_REGS  = 7;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_CONFIG = 2'd2;

	localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
	localparam logic [7:0] CMD_CONVERT   = 8'h44;
	localparam logic [7:0] CMD_READ_PAD  = 8'hBE;
	localparam logic [7:0] CMD_WRITE_PAD = 8'h4E;
	localparam logic [7:0] CFG_TH        = 8'h20;
	localparam logic [7:0] CFG_TL        = 8'h00;
	localparam logic [7:0] CFG_RES       = 8'h7F;

	localparam logic [3:0] READ_STEPS   = 4'd9;
	localparam logic [3:0] CONFIG_STEPS = 4'd7;
	localparam logic [3:0] READ_LOW_STEP = 4'd6;

	typedef enum logic [2:0] {
		REG_RESET_LOW     = 3'd0,
		REG_PRESENCE_WAIT = 3'd1,
		REG_RESET_TAIL    = 3'd2,
		REG_SLOT_LOW      = 3'd3,
		REG_WRITE_HOLD    = 3'd4,
		REG_READ_SAMPLE   = 3'd5,
		REG_SLOT_TAIL     = 3'd6
	} reg_index_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_RST_TAIL = 4'd3,
		PH_W_LOW    = 4'd4,
		PH_W_HOLD   = 4'd5,
		PH_R_LOW    = 4'd6,
		PH_R_WAIT   = 4'd7,
		PH_R_TAIL   = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		STEP_BYTE  = 2'd0,
		STEP_RESET = 2'd1,
		STEP_READ  = 2'd2
	} step_kind_t;

	typedef struct packed {
		step_kind_t  kind;
		logic [7:0]  value;
	} step_t;

	typedef struct packed {
		logic [REG_WIDTH-1:0] reset_low;
		logic [REG_WIDTH-1:0] presence_wait;
		logic [REG_WIDTH-1:0] reset_tail;
		logic [REG_WIDTH-1:0] slot_low;
		logic [REG_WIDTH-1:0] write_hold;
		logic [REG_WIDTH-1:0] read_sample;
		logic [REG_WIDTH-1:0] slot_tail;
	} regs_t;

	typedef struct packed {
		logic [1:0] operation;
		logic       line_level;
	} in_word_t;

	typedef struct packed {
		logic        drive_low;
		logic        busy_res;
		logic        done_res;
		logic [15:0] temperature_raw;
		logic        presence_fault;
	} out_word_t;

	typedef struct packed {
		logic [2:0]           index;
		logic [REG_WIDTH-1:0] wdata;
	} cfg_word_t;

	function automatic logic [3:0] plan_count(input logic kind);
		return kind ? CONFIG_STEPS : READ_STEPS;
	endfunction

	function automatic step_t plan_step(input logic kind, input logic [3:0] idx);
		step_t s;
		s = '{kind: STEP_RESET, value: 8'h00};
		if (!kind) begin
			case (idx)
				4'd1, 4'd4: s = '{kind: STEP_BYTE, value: CMD_SKIP_ROM};
				4'd2:       s = '{kind: STEP_BYTE, value: CMD_CONVERT};
				4'd5:       s = '{kind: STEP_BYTE, value: CMD_READ_PAD};
				4'd6, 4'd7: s = '{kind: STEP_READ, value: 8'h00};
				default:    s = '{kind: STEP_RESET, value: 8'h00};
			endcase
		end else begin
			case (idx)
				4'd1:    s = '{kind: STEP_BYTE, value: CMD_SKIP_ROM};
				4'd2:    s = '{kind: STEP_BYTE, value: CMD_WRITE_PAD};
				4'd3:    s = '{kind: STEP_BYTE, value: CFG_TH};
				4'd4:    s = '{kind: STEP_BYTE, value: CFG_TL};
				4'd5:    s = '{kind: STEP_BYTE, value: CFG_RES};
				default: s = '{kind: STEP_RESET, value: 8'h00};
			endcase
		end
		return s;
	endfunction

endpackage

// ===== rtl/owt_stream_if.sv =====
// ----------------------------------------------------------------------------
// owt_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface owt_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/owt_timer.sv =====
// ----------------------------------------------------------------------------
// owt_timer
// Phase length select and end-of-phase compare for the bus sequencer.
// ----------------------------------------------------------------------------
module owt_timer
	import owt_pkg::*;
#(
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  phase_t                      phase,
	input  regs_t                       regs,
	input  logic [TICK_COUNT_WIDTH-1:0] tick_count,
	output logic                        last
);

	localparam int LW = ((TICK_COUNT_WIDTH > REG_WIDTH) ? TICK_COUNT_WIDTH : REG_WIDTH) + 1;

	logic [REG_WIDTH-1:0] n;
	logic [LW-1:0]        n_ext;
	logic [LW-1:0]        cap;
	logic [LW-1:0]        len;
	logic [LW-1:0]        tc_plus;

	always_comb begin
		unique case (phase) inside
			PH_RST_LOW:         n = regs.reset_low;
			PH_RST_WAIT:        n = regs.presence_wait;
			PH_RST_TAIL:        n = regs.reset_tail;
			PH_W_LOW, PH_R_LOW: n = regs.slot_low;
			PH_W_HOLD:          n = regs.write_hold;
			PH_R_WAIT:          n = regs.read_sample;
			default:            n = regs.slot_tail;
		endcase
	end

	assign n_ext   = LW'(n);
	assign cap     = LW'(1) << TICK_COUNT_WIDTH;
	assign tc_plus = LW'(tick_count) + LW'(1);

	always_comb begin
		if (n_ext > cap)
			len = cap;
		else if (n_ext == '0)
			len = LW'(1);
		else
			len = n_ext;
	end

	assign last = (tc_plus >= len);

endmodule

// ===== rtl/owt_seq.sv =====
// ----------------------------------------------------------------------------
// owt_seq
// Bus sequencer: one tick per advance, runs reset, write and read slots.
// ----------------------------------------------------------------------------
module owt_seq
	import owt_pkg::*;
#(
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  in_word_t  tick,
	input  regs_t     regs,
	output out_word_t result
);

	phase_t                      phase_q, phase_a, phase_n;
	logic [TICK_COUNT_WIDTH-1:0] tc_q, tc_a, tc_n;
	logic [3:0]                  step_q, step_a, step_n;
	logic [2:0]                  bit_q, bit_a, bit_n;
	logic [7:0]                  sb_q, sb_n;
	logic                        kind_q, kind_a, kind_n;
	logic [15:0]                 temp_q, temp_n;
	logic                        fault_q, fault_n;
	logic                        done_n;
	logic                        start;
	logic                        last;
	logic [3:0]                  nxt_idx;
	step_t                       nxt_step;
	logic                        nxt_end;

	assign start   = (phase_q == PH_IDLE) &&
	                 ((tick.operation == OP_READ) || (tick.operation == OP_CONFIG));
	assign phase_a = start ? PH_RST_LOW : phase_q;
	assign tc_a    = start ? '0 : tc_q;
	assign step_a  = start ? 4'd0 : step_q;
	assign bit_a   = start ? 3'd0 : bit_q;
	assign kind_a  = start ? (tick.operation == OP_CONFIG) : kind_q;

	assign nxt_idx  = step_a + 4'd1;
	assign nxt_step = plan_step(kind_a, nxt_idx);
	assign nxt_end  = (nxt_idx >= plan_count(kind_a));

	owt_timer #(
		.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
	) u_timer (
		.phase      (phase_a),
		.regs       (regs),
		.tick_count (tc_a),
		.last       (last)
	);

	always_comb begin
		logic go_next;
		go_next = 1'b0;
		phase_n = phase_a;
		tc_n    = tc_a;
		step_n  = step_a;
		bit_n   = bit_a;
		sb_n    = sb_q;
		kind_n  = kind_a;
		temp_n  = temp_q;
		fault_n = fault_q;
		done_n  = 1'b0;
		if (phase_a != PH_IDLE) begin
			if (!last) begin
				tc_n = tc_a + TICK_COUNT_WIDTH'(1);
			end else begin
				tc_n = '0;
				unique case (phase_a) inside
					PH_RST_LOW: phase_n = PH_RST_WAIT;
					PH_RST_WAIT: begin
						fault_n = tick.line_level;
						phase_n = PH_RST_TAIL;
					end
					PH_RST_TAIL: go_next = 1'b1;
					PH_W_LOW: phase_n = PH_W_HOLD;
					PH_W_HOLD: begin
						sb_n = {1'b0, sb_q[7:1]};
						if (bit_a == 3'd7) begin
							go_next = 1'b1;
						end else begin
							bit_n   = bit_a + 3'd1;
							phase_n = PH_W_LOW;
						end
					end
					PH_R_LOW: phase_n = PH_R_WAIT;
					PH_R_WAIT: begin
						sb_n    = {tick.line_level, sb_q[7:1]};
						phase_n = PH_R_TAIL;
					end
					default: begin
						if (bit_a == 3'd7) begin
							if (step_a == READ_LOW_STEP)
								temp_n = {temp_q[15:8], sb_q};
							else
								temp_n = {sb_q, temp_q[7:0]};
							go_next = 1'b1;
						end else begin
							bit_n   = bit_a + 3'd1;
							phase_n = PH_R_LOW;
						end
					end
				endcase
				if (go_next) begin
					if (nxt_end) begin
						phase_n = PH_IDLE;
						step_n  = 4'd0;
						done_n  = 1'b1;
					end else begin
						step_n = nxt_idx;
						bit_n  = 3'd0;
						case (nxt_step.kind)
							STEP_RESET: phase_n = PH_RST_LOW;
							STEP_READ: begin
								sb_n    = 8'h00;
								phase_n = PH_R_LOW;
							end
							default: begin
								sb_n    = nxt_step.value;
								phase_n = PH_W_LOW;
							end
						endcase
					end
				end
			end
		end
	end

	always_comb begin
		result = '0;
		result.busy_res        = (phase_a != PH_IDLE);
		result.done_res        = done_n;
		result.temperature_raw = temp_n;
		result.presence_fault  = fault_n;
		unique case (phase_a) inside
			PH_RST_LOW, PH_W_LOW, PH_R_LOW: result.drive_low = 1'b1;
			PH_W_HOLD:                      result.drive_low = ~sb_q[0];
			default:                        result.drive_low = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tc_q    <= '0;
			step_q  <= 4'd0;
			bit_q   <= 3'd0;
			sb_q    <= 8'h00;
			kind_q  <= 1'b0;
			temp_q  <= 16'h0000;
			fault_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_n;
			tc_q    <= tc_n;
			step_q  <= step_n;
			bit_q   <= bit_n;
			sb_q    <= sb_n;
			kind_q  <= kind_n;
			temp_q  <= temp_n;
			fault_q <= fault_n;
		end
	end

endmodule

// ===== rtl/onewire_temp_sensor_master_core.sv =====
// ----------------------------------------------------------------------------
// onewire_temp_sensor_master_core
// One-wire bus master for a temperature sensor, stepped by bus tick words.
// ----------------------------------------------------------------------------
// Each input word is one bus tick and yields exactly one result word. The core
// sustains one word per clock cycle while the output is ready; a tick passes
// from the input register through the sequencer, and its result is held in the
// result register until taken. Slot timings sit in seven registers written over
// the cfg channel, which is always ready; an index of seven is ignored.
module onewire_temp_sensor_master_core
	import owt_pkg::*;
#(
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	owt_stream_if.sink        in,
	owt_stream_if.source      out,
	owt_stream_if.sink        cfg
);

	in_word_t  in_s1;
	logic      v_s1;
	out_word_t res_s2;
	logic      v_s2;
	out_word_t res_n;
	logic      move;
	regs_t     regs_q;

	assign move     = v_s1 && (!v_s2 || out.ready);
	assign in.ready = !v_s1 || move;
	assign cfg.ready = 1'b1;
	assign out.valid = v_s2;
	assign out.data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.reset_low     <= 16'd480;
			regs_q.presence_wait <= 16'd70;
			regs_q.reset_tail    <= 16'd410;
			regs_q.slot_low      <= 16'd2;
			regs_q.write_hold    <= 16'd60;
			regs_q.read_sample   <= 16'd10;
			regs_q.slot_tail     <= 16'd55;
		end else if (cfg.valid) begin
			unique case (reg_index_t'(cfg.data.index))
				REG_RESET_LOW:     regs_q.reset_low     <= cfg.data.wdata;
				REG_PRESENCE_WAIT: regs_q.presence_wait <= cfg.data.wdata;
				REG_RESET_TAIL:    regs_q.reset_tail    <= cfg.data.wdata;
				REG_SLOT_LOW:      regs_q.slot_low      <= cfg.data.wdata;
				REG_WRITE_HOLD:    regs_q.write_hold    <= cfg.data.wdata;
				REG_READ_SAMPLE:   regs_q.read_sample   <= cfg.data.wdata;
				REG_SLOT_TAIL:     regs_q.slot_tail     <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in.ready)
				v_s1 <= in.valid;
			if (move)
				v_s2 <= 1'b1;
			else if (out.ready)
				v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready)
			in_s1 <= in.data;
		if (move)
			res_s2 <= res_n;
	end

	owt_seq #(
		.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (move),
		.tick    (in_s1),
		.regs    (regs_q),
		.result  (res_n)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && out.data.done_res) |-> out.data.busy_res)
		else $error("done word without busy");

	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && out.data.drive_low) |-> out.data.busy_res)
		else $error("line driven outside a sequence");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		move |-> (!v_s2 || out.ready))
		else $error("result word overwritten while held");

endmodule
